FILE: rtl/rlml_pkg.sv
// shared constants and types for the register location map lookup
package rlml_pkg;
   localparam int TABLE_DEPTH = 256;
   localparam int MAX_HITS = 16;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = IDX_W + 1;
   localparam int HITS_W = $clog2(MAX_HITS + 1);

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_FINAL = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   localparam logic [1:0] KIND_HIT = 2'd0;
   localparam logic [1:0] KIND_SUMMARY = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // one table entry as stored in memory
   typedef struct packed {
      logic [15:0] func;
      logic [63:0] key;
      logic [1:0] part;
      logic [31:0] target;
      logic [31:0] start;
      logic [31:0] fin;
   } entry_type;
endpackage

FILE: rtl/register_location_map_lookup_unit.sv
// top level: entry table with append, finalize and query sequencer
// clear and append answer in the cycle after start; a query walks all stored entries;
// finalize makes a pairwise walk over the entry memory, one read per cycle
// throughput: one request at a time, busy stays high until the last result
// reset clears the entry count, the extrapolate register and the sequencer;
// results cannot be stalled, each is shown for one cycle under rsp_valid
module register_location_map_lookup_unit (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_opcode,
   input  logic [15:0] req_func_id,
   input  logic [63:0] req_reg_key,
   input  logic [1:0] req_part_index,
   input  logic [31:0] req_target_word,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic [31:0] req_query_addr,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_data,
   output logic rsp_valid,
   output logic [1:0] rsp_kind,
   output logic rsp_status,
   output logic [31:0] rsp_hit_target,
   output logic rsp_hit_part,
   output logic [8:0] rsp_hit_count,
   output logic rsp_readable,
   output logic rsp_writable,
   output logic rsp_extrapolated,
   output logic rsp_hits_dropped,
   output logic rsp_last
);
   import rlml_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_QRD  = 8'b00000010,
      S_QCHK = 8'b00000100,
      S_SUM  = 8'b00001000,
      S_MAX  = 8'b00010000,
      S_OUT  = 8'b00100000,
      S_INN  = 8'b01000000,
      S_WB   = 8'b10000000
   } state_type;

   // entry stores: main record and extended end
   entry_type mem [TABLE_DEPTH];
   logic [31:0] ext_mem [TABLE_DEPTH];

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic ext_en_ff;
   logic [15:0] fid_ff;
   logic [63:0] key_ff;
   logic [31:0] addr_ff;
   logic [CNT_W-1:0] i_ff, i_in, k_ff, k_in;
   logic rd_pend_ff, rd_pend_in;
   logic [31:0] top_ff, top_in, ext_ff, ext_in;
   logic brk_ff, brk_in;
   entry_type cur_ff, cur_in;
   logic [8:0] total_ff, total_in, cnt0_ff, cnt0_in, cnt1_ff, cnt1_in;
   logic [1:0] maxp_ff, maxp_in;
   logic any_ff, any_in, extra_ff, extra_in, drop_ff, drop_in;
   logic [HITS_W-1:0] emit_ff, emit_in;

   // memory ports
   logic [IDX_W-1:0] raddr;
   entry_type rdata_ff;
   logic [31:0] rext_ff;
   logic we, ext_we;
   logic [IDX_W-1:0] waddr, ext_waddr;
   entry_type wdata;
   logic [31:0] ext_wdata;

   // response register
   logic rv_ff, rv_in;
   logic [1:0] rk_ff, rk_in;
   logic rs_ff, rs_in, rp_ff, rp_in, rr_ff, rr_in, rw_ff, rw_in;
   logic re_ff, re_in, rdr_ff, rdr_in, rl_ff, rl_in;
   logic [31:0] rt_ff, rt_in;
   logic [8:0] rc_ff, rc_in;

   // memories
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (ext_we) ext_mem[ext_waddr] <= ext_wdata;
      rdata_ff <= mem[raddr];
      rext_ff <= ext_mem[raddr];
   end

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   logic [31:0] lim;
   logic hit;
   logic rdf, wrf;
   always_comb begin
      state_in = state_ff; count_in = count_ff;
      i_in = i_ff; k_in = k_ff; rd_pend_in = 1'b0;
      top_in = top_ff; ext_in = ext_ff; brk_in = brk_ff; cur_in = cur_ff;
      total_in = total_ff; cnt0_in = cnt0_ff; cnt1_in = cnt1_ff;
      maxp_in = maxp_ff; any_in = any_ff; extra_in = extra_ff;
      drop_in = drop_ff; emit_in = emit_ff;
      raddr = i_ff[IDX_W-1:0];
      we = 1'b0; waddr = count_ff[IDX_W-1:0];
      wdata = '{req_func_id, req_reg_key, req_part_index, req_target_word,
                req_range_start, req_range_end};
      ext_we = 1'b0; ext_waddr = count_ff[IDX_W-1:0]; ext_wdata = req_range_end;
      rv_in = 1'b0; rk_in = KIND_STATUS; rs_in = 1'b0; rt_in = '0; rp_in = 1'b0;
      rc_in = '0; rr_in = 1'b0; rw_in = 1'b0; re_in = 1'b0; rdr_in = 1'b0;
      rl_in = 1'b0;
      lim = ext_en_ff ? rext_ff : rdata_ff.fin;
      hit = (addr_ff >= rdata_ff.start) && (addr_ff <= lim) && !rdata_ff.part[1];
      rdf = 1'b0; wrf = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               i_in = '0; k_in = '0;
               total_in = '0; cnt0_in = '0; cnt1_in = '0; maxp_in = '0;
               any_in = 1'b0; extra_in = 1'b0; drop_in = 1'b0; emit_in = '0;
               top_in = '0;
               case (req_opcode)
                  OP_CLEAR: begin
                     count_in = '0; rv_in = 1'b1; rl_in = 1'b1;
                  end
                  OP_APPEND: begin
                     rv_in = 1'b1; rl_in = 1'b1;
                     if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                        we = 1'b1; ext_we = 1'b1; count_in = count_ff + 1'b1;
                     end else begin
                        rs_in = 1'b1;
                     end
                  end
                  OP_FINAL: state_in = S_MAX;
                  default: state_in = S_QRD;
               endcase
            end
         end
         // query: issue read of entry i
         S_QRD: begin
            if (i_ff < count_ff) begin
               state_in = S_QCHK; i_in = i_ff + 1'b1;
            end else begin
               state_in = S_SUM;
            end
         end
         S_QCHK: begin
            state_in = S_QRD;
            if (rdata_ff.func == fid_ff && rdata_ff.key == key_ff) begin
               if (!any_ff || rdata_ff.part > maxp_ff) maxp_in = rdata_ff.part;
               any_in = 1'b1;
               if (hit) begin
                  if (rdata_ff.part[0]) cnt1_in = cnt1_ff + 1'b1;
                  else cnt0_in = cnt0_ff + 1'b1;
                  if (total_ff != 9'd511) total_in = total_ff + 1'b1;
                  if (ext_en_ff && addr_ff > rdata_ff.fin) extra_in = 1'b1;
                  if (emit_ff < HITS_W'(MAX_HITS)) begin
                     emit_in = emit_ff + 1'b1;
                     rv_in = 1'b1; rk_in = KIND_HIT;
                     rt_in = rdata_ff.target; rp_in = rdata_ff.part[0];
                  end else begin
                     drop_in = 1'b1;
                  end
               end
            end
         end
         S_SUM: begin
            if (total_ff != '0) begin
               rdf = 1'b1; wrf = !extra_ff;
               if (cnt0_ff == '0) begin rdf = 1'b0; wrf = 1'b0; end
               if (maxp_ff != 2'd0) begin
                  if (cnt1_ff == '0) begin rdf = 1'b0; wrf = 1'b0; end
                  if (cnt1_ff != cnt0_ff) wrf = 1'b0;
               end
               // parts 2 and 3 never hit
               if (maxp_ff[1]) begin rdf = 1'b0; wrf = 1'b0; end
            end
            rv_in = 1'b1; rk_in = KIND_SUMMARY; rl_in = 1'b1;
            rc_in = total_ff; rr_in = rdf; rw_in = wrf;
            re_in = extra_ff; rdr_in = drop_ff;
            state_in = S_IDLE;
         end
         // finalize pass 1: max end; reads pipelined with rd_pend
         S_MAX: begin
            if (rd_pend_ff && rdata_ff.func == fid_ff && rdata_ff.fin > top_ff)
               top_in = rdata_ff.fin;
            if (i_ff < count_ff) begin
               i_in = i_ff + 1'b1; rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = S_OUT; i_in = '0;
            end
         end
         // outer entry: read i, then walk k
         S_OUT: begin
            if (i_ff >= count_ff) begin
               state_in = S_IDLE; rv_in = 1'b1; rl_in = 1'b1;
            end else if (!rd_pend_ff) begin
               rd_pend_in = 1'b1;
            end else begin
               cur_in = rdata_ff; ext_in = top_ff; brk_in = 1'b0; k_in = '0;
               if (rdata_ff.func == fid_ff) state_in = S_INN;
               else i_in = i_ff + 1'b1;
            end
         end
         S_INN: begin
            raddr = k_ff[IDX_W-1:0];
            if (rd_pend_ff && !brk_ff && (k_ff - 1'b1) != i_ff &&
                rdata_ff.func == fid_ff && rdata_ff.key == cur_ff.key) begin
               if (rdata_ff.start >= cur_ff.fin) begin
                  if (rdata_ff.start < ext_ff) ext_in = rdata_ff.start;
               end else if (rdata_ff.fin > cur_ff.fin) begin
                  ext_in = cur_ff.fin; brk_in = 1'b1;
               end
            end
            if (k_ff < count_ff) begin
               k_in = k_ff + 1'b1; rd_pend_in = 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            ext_we = 1'b1; ext_waddr = i_ff[IDX_W-1:0]; ext_wdata = ext_ff;
            i_in = i_ff + 1'b1; state_in = S_OUT;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; ext_en_ff <= 1'b0;
         rv_ff <= 1'b0; rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; rv_ff <= rv_in;
         rd_pend_ff <= rd_pend_in;
         if (csr_valid) ext_en_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         fid_ff <= req_func_id;
         key_ff <= req_reg_key; addr_ff <= req_query_addr;
      end
      i_ff <= i_in; k_ff <= k_in; top_ff <= top_in; ext_ff <= ext_in;
      brk_ff <= brk_in; cur_ff <= cur_in; total_ff <= total_in;
      cnt0_ff <= cnt0_in; cnt1_ff <= cnt1_in; maxp_ff <= maxp_in;
      any_ff <= any_in; extra_ff <= extra_in; drop_ff <= drop_in; emit_ff <= emit_in;
      rk_ff <= rk_in; rs_ff <= rs_in; rt_ff <= rt_in; rp_ff <= rp_in; rc_ff <= rc_in;
      rr_ff <= rr_in; rw_ff <= rw_in; re_ff <= re_in; rdr_ff <= rdr_in; rl_ff <= rl_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_kind = rk_ff;
   assign rsp_status = rs_ff;
   assign rsp_hit_target = rt_ff;
   assign rsp_hit_part = rp_ff;
   assign rsp_hit_count = rc_ff;
   assign rsp_readable = rr_ff;
   assign rsp_writable = rw_ff;
   assign rsp_extrapolated = re_ff;
   assign rsp_hits_dropped = rdr_ff;
   assign rsp_last = rl_ff;
endmodule

FILE: rtl/rlml_checker.sv
// port level checks for the lookup unit, bound to the top level
module rlml_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic [1:0] rsp_kind,
   input logic rsp_last,
   input logic rsp_writable,
   input logic rsp_readable
);
   import rlml_pkg::*;

   // a hit is never the final result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_HIT |-> !rsp_last)
      else $error("hit marked last");
   // summary and status always close the request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_HIT |-> rsp_last)
      else $error("closing result not last");
   // writable implies readable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_writable |-> rsp_readable)
      else $error("writable without readable");
   // no result while idle unless a request has just started or finished
   assert property (@(posedge clock) disable iff (reset)
      !busy && !$past(busy) && !$past(start) |-> !rsp_valid)
      else $error("spurious result");
endmodule

bind register_location_map_lookup_unit rlml_checker u_rlml_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_last(rsp_last),
   .rsp_writable(rsp_writable), .rsp_readable(rsp_readable)
);
